// File: sv/sclp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared types and constants for the segment / lookahead circle point core.
// ----------------------------------------------------------------------------
package sclp_pkg;

	localparam int SCLP_COORD_BITS = 24;

	// operations of the shared arithmetic engine
	typedef enum logic [1:0] {
		EOP_MAC,
		EOP_SQRT,
		EOP_DIV
	} eng_op_t;

	// phases of a division
	typedef enum logic [1:0] {
		DPH_ABS,
		DPH_STEP,
		DPH_RND
	} div_ph_t;

	typedef struct packed {
		eng_op_t op;
		logic    clr;
		logic    neg;
	} eng_cmd_t;

	typedef struct packed {
		logic done;
		logic rnd;
		logic qneg;
	} eng_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_L1,
		ST_L2,
		ST_D1,
		ST_D2,
		ST_R2,
		ST_RL,
		ST_DD,
		ST_SQ,
		ST_PX,
		ST_PY,
		ST_PT,
		ST_PU,
		ST_N0,
		ST_N1,
		ST_DV,
		ST_CHK,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_FIN
	} seq_state_t;

endpackage
`default_nettype wire

// File: sv/segment_circle_lookahead_point_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_circle_lookahead_point_core
// Pure pursuit lookahead point: intersection of a path segment with the
// lookahead circle around the robot, nearest valid point to the segment end.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel in_valid / in_ready carries one request: segment start and
//    end, robot position and lookahead radius (signed fixed point coordinates)
//  - output channel out_valid / out_ready returns target_x, target_y, fresh
//  - every request gives exactly one result; with no valid intersection the
//    held target is returned with fresh low
//  - one request at a time: in_ready is high only while the sequencer idles
//  - latency is data dependent, set by the serial shift-add engine: each
//    multiply runs until its multiplier is shifted out; the square root and
//    each of the four divisions work out one result bit per step
//  - a zero-length segment goes to the final state as soon as its length
//    is known, without the full computation; the next request is taken
//    the cycle after the result is registered
//  - the result sits in an output register; a stalled receiver holds the core
//    in its final state until the register frees up
//  - reset clears the held target to zero and empties the output register
// ----------------------------------------------------------------------------
module segment_circle_lookahead_point_core import sclp_pkg::*; #(
	parameter int COORD_BITS = SCLP_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	input  logic signed [COORD_BITS-1:0] robot_x,
	input  logic signed [COORD_BITS-1:0] robot_y,
	input  logic        [COORD_BITS-2:0] lookahead_radius,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] target_x,
	output logic signed [COORD_BITS-1:0] target_y,
	output logic                         fresh
);

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int AW  = 4 * C + 4;
	localparam int LW  = 2 * C + 1;
	localparam int DDW = 2 * C + 2;
	localparam int PW  = 3 * C + 2;
	localparam int QB  = C + 2;
	localparam int XW  = C + 4;
	localparam logic signed [XW-1:0] SMAX = {{(XW-C+1){1'b0}}, {(C-1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = ~SMAX;

	seq_state_t state_q, state_d;
	logic       run_q, start;
	eng_cmd_t   cmd;
	eng_sts_t   eng_sts;
	logic [AW-1:0] opa, opb, eng_acc;
	logic [2*C-1:0] eng_root;
	logic [QB:0]    eng_quo;

	logic signed [C-1:0] sx_q, sy_q, ex_q, ey_q, rx_q, ry_q;
	logic [C-2:0]        r_q;
	logic [LW-1:0]       len_q;
	logic signed [DDW-1:0] d_q;
	logic [2*C-3:0]      r2_q;
	logic [2*C-1:0]      q_q;
	logic signed [PW-1:0] p_q, ny_q, t_q, u_q;
	logic signed [XW-1:0] xy_q [4];
	logic [1:0]          k_q;
	logic                found_q, sel1_q;
	logic                ov_q, fresh_q;
	logic signed [C-1:0] held_x_q, held_y_q, tx_q, ty_q;

	// differences and magnitudes
	logic signed [DW-1:0] dx, dy, mx, my;
	logic [DW-1:0]        dxm, dym, mxm, mym;
	logic [DDW-1:0]       dm;

	assign dx  = DW'(ex_q) - DW'(sx_q);
	assign dy  = DW'(ey_q) - DW'(sy_q);
	assign mx  = DW'(sx_q) - DW'(rx_q);
	assign my  = DW'(sy_q) - DW'(ry_q);
	assign dxm = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign dym = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign mxm = mx[DW-1] ? DW'(-mx) : DW'(mx);
	assign mym = my[DW-1] ? DW'(-my) : DW'(my);
	assign dm  = d_q[DDW-1] ? DDW'(-d_q) : DDW'(d_q);

	// rounded quotient back to field coordinates
	logic [QB:0]          qsum, qmag;
	logic signed [XW-1:0] qs, coord;
	logic signed [C-1:0]  base;

	assign qsum  = eng_quo + {{QB{1'b0}}, eng_sts.rnd};
	assign qmag  = eng_quo[QB] ? {1'b1, {QB{1'b0}}} : qsum;
	assign qs    = eng_sts.qneg ? -$signed(XW'(qmag)) : $signed(XW'(qmag));
	assign base  = k_q[1] ? ry_q : rx_q;
	assign coord = qs + XW'(base);

	// bounding box check
	logic signed [XW-1:0] lx, hx, ly, hy;
	logic                 v1, v2;

	assign lx = (sx_q < ex_q) ? XW'(sx_q) : XW'(ex_q);
	assign hx = (sx_q < ex_q) ? XW'(ex_q) : XW'(sx_q);
	assign ly = (sy_q < ey_q) ? XW'(sy_q) : XW'(ey_q);
	assign hy = (sy_q < ey_q) ? XW'(ey_q) : XW'(sy_q);
	assign v1 = lx <= xy_q[0] && xy_q[0] <= hx && ly <= xy_q[2] && xy_q[2] <= hy;
	assign v2 = lx <= xy_q[1] && xy_q[1] <= hx && ly <= xy_q[3] && xy_q[3] <= hy;

	// offsets of both points from the segment end
	logic signed [XW-1:0] ed [4];
	logic [XW-1:0]        em [4];

	assign ed[0] = xy_q[0] - XW'(ex_q);
	assign ed[1] = xy_q[2] - XW'(ey_q);
	assign ed[2] = xy_q[1] - XW'(ex_q);
	assign ed[3] = xy_q[3] - XW'(ey_q);
	always_comb begin
		for (int i = 0; i < 4; i++)
			em[i] = ed[i][XW-1] ? XW'(-ed[i]) : XW'(ed[i]);
	end

	// selected point, saturated
	logic signed [XW-1:0] chx, chy;
	logic signed [C-1:0]  satx, saty;

	assign chx  = sel1_q ? xy_q[0] : xy_q[1];
	assign chy  = sel1_q ? xy_q[2] : xy_q[3];
	assign satx = (chx > SMAX) ? SMAX[C-1:0] : ((chx < SMIN) ? SMIN[C-1:0] : chx[C-1:0]);
	assign saty = (chy > SMAX) ? SMAX[C-1:0] : ((chy < SMIN) ? SMIN[C-1:0] : chy[C-1:0]);

	logic accept, fin_go;

	assign accept = in_valid && in_ready;
	assign fin_go = (state_q == ST_FIN) && (!ov_q || out_ready);

	sclp_engine #(
		.COORD_BITS(COORD_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.sts    (eng_sts),
		.acc    (eng_acc),
		.root   (eng_root),
		.quo    (eng_quo)
	);

	// sequencer: next state and engine operands
	always_comb begin
		state_d  = state_q;
		cmd      = '{op: EOP_MAC, clr: 1'b1, neg: 1'b0};
		opa      = '0;
		opb      = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_L1;
			ST_L1: begin
				opa = AW'(dxm);
				opb = AW'(dxm);
				if (eng_sts.done) state_d = ST_L2;
			end
			ST_L2: begin
				cmd.clr = 1'b0;
				opa = AW'(dym);
				opb = AW'(dym);
				if (eng_sts.done) state_d = (eng_acc == '0) ? ST_FIN : ST_D1;
			end
			ST_D1: begin
				opa = AW'(mxm);
				opb = AW'(dym);
				cmd.neg = mx[DW-1] ^ dy[DW-1];
				if (eng_sts.done) state_d = ST_D2;
			end
			ST_D2: begin
				cmd.clr = 1'b0;
				opa = AW'(mym);
				opb = AW'(dxm);
				cmd.neg = !(dx[DW-1] ^ my[DW-1]);
				if (eng_sts.done) state_d = ST_R2;
			end
			ST_R2: begin
				opa = AW'(r_q);
				opb = AW'(r_q);
				if (eng_sts.done) state_d = ST_RL;
			end
			ST_RL: begin
				opa = AW'(r2_q);
				opb = AW'(len_q);
				if (eng_sts.done) state_d = ST_DD;
			end
			ST_DD: begin
				cmd.clr = 1'b0;
				cmd.neg = 1'b1;
				opa = AW'(dm);
				opb = AW'(dm);
				// line misses the circle
				if (eng_sts.done) state_d = eng_acc[AW-1] ? ST_FIN : ST_SQ;
			end
			ST_SQ: begin
				cmd.op = EOP_SQRT;
				if (eng_sts.done) state_d = ST_PX;
			end
			ST_PX: begin
				opa = AW'(dm);
				opb = AW'(dym);
				cmd.neg = d_q[DDW-1] ^ dy[DW-1];
				if (eng_sts.done) state_d = ST_PY;
			end
			ST_PY: begin
				opa = AW'(dm);
				opb = AW'(dxm);
				cmd.neg = !(d_q[DDW-1] ^ dx[DW-1]);
				if (eng_sts.done) state_d = ST_PT;
			end
			ST_PT: begin
				opa = AW'(q_q);
				opb = AW'(dxm);
				cmd.neg = dy[DW-1] ^ dx[DW-1];
				if (eng_sts.done) state_d = ST_PU;
			end
			ST_PU: begin
				opa = AW'(q_q);
				opb = AW'(dym);
				if (eng_sts.done) state_d = ST_N0;
			end
			ST_N0: begin
				opa = k_q[1] ? AW'(ny_q) : AW'(p_q);
				opb = AW'(1'b1);
				if (eng_sts.done) state_d = ST_N1;
			end
			ST_N1: begin
				cmd.clr = 1'b0;
				cmd.neg = k_q[0];
				opa = k_q[1] ? AW'(u_q) : AW'(t_q);
				opb = AW'(1'b1);
				if (eng_sts.done) state_d = ST_DV;
			end
			ST_DV: begin
				cmd.op = EOP_DIV;
				opa = AW'(len_q);
				if (eng_sts.done) state_d = (&k_q) ? ST_CHK : ST_N0;
			end
			ST_CHK: state_d = (v1 && v2) ? ST_E1 : ST_FIN;
			ST_E1: begin
				opa = AW'(em[0]);
				opb = AW'(em[0]);
				if (eng_sts.done) state_d = ST_E2;
			end
			ST_E2: begin
				cmd.clr = 1'b0;
				opa = AW'(em[1]);
				opb = AW'(em[1]);
				if (eng_sts.done) state_d = ST_E3;
			end
			ST_E3: begin
				cmd.clr = 1'b0;
				cmd.neg = 1'b1;
				opa = AW'(em[2]);
				opb = AW'(em[2]);
				if (eng_sts.done) state_d = ST_E4;
			end
			ST_E4: begin
				cmd.clr = 1'b0;
				cmd.neg = 1'b1;
				opa = AW'(em[3]);
				opb = AW'(em[3]);
				if (eng_sts.done) state_d = ST_FIN;
			end
			ST_FIN: if (fin_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		start = !run_q && (state_q != ST_IDLE) && (state_q != ST_CHK) && (state_q != ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			k_q      <= '0;
			found_q  <= 1'b0;
			sel1_q   <= 1'b0;
			ov_q     <= 1'b0;
			fresh_q  <= 1'b0;
			held_x_q <= '0;
			held_y_q <= '0;
		end else begin
			if (start)
				run_q <= 1'b1;
			else if (eng_sts.done)
				run_q <= 1'b0;
			if (accept) begin
				k_q     <= '0;
				found_q <= 1'b0;
			end
			if (state_q == ST_DV && eng_sts.done)
				k_q <= k_q + 1'b1;
			if (state_q == ST_CHK && !(v1 && v2)) begin
				found_q <= v1 || v2;
				sel1_q  <= v1;
			end
			// first point wins only when strictly nearer the end
			if (state_q == ST_E4 && eng_sts.done) begin
				found_q <= 1'b1;
				sel1_q  <= eng_acc[AW-1];
			end
			if (fin_go) begin
				ov_q    <= 1'b1;
				fresh_q <= found_q;
				if (found_q) begin
					held_x_q <= satx;
					held_y_q <= saty;
				end
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sx_q <= seg_start_x;
			sy_q <= seg_start_y;
			ex_q <= seg_end_x;
			ey_q <= seg_end_y;
			rx_q <= robot_x;
			ry_q <= robot_y;
			r_q  <= lookahead_radius;
		end
		if (eng_sts.done) begin
			case (state_q)
				ST_L2: len_q <= eng_acc[LW-1:0];
				ST_D2: d_q   <= eng_acc[DDW-1:0];
				ST_R2: r2_q  <= eng_acc[2*C-3:0];
				ST_SQ: q_q   <= eng_root;
				ST_PX: p_q   <= eng_acc[PW-1:0];
				ST_PY: ny_q  <= eng_acc[PW-1:0];
				ST_PT: t_q   <= eng_acc[PW-1:0];
				ST_PU: u_q   <= eng_acc[PW-1:0];
				ST_DV: xy_q[k_q] <= coord;
				default: ;
			endcase
		end
		if (fin_go) begin
			tx_q <= found_q ? satx : held_x_q;
			ty_q <= found_q ? saty : held_y_q;
		end
	end

	assign out_valid = ov_q;
	assign target_x  = tx_q;
	assign target_y  = ty_q;
	assign fresh     = fresh_q;

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !fresh_q) |-> (tx_q == held_x_q && ty_q == held_y_q))
		else $error("held result differs from stored target");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		eng_sts.done |-> run_q)
		else $error("engine finished without a running operation");

	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DV) |-> (len_q != '0))
		else $error("division by zero segment length");

	a_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && found_q) |-> (sel1_q ? v1 : v2))
		else $error("selected point lies outside the segment box");

endmodule
`default_nettype wire

// File: sv/sclp_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sclp_engine
// Shared shift-add unit: bit-serial multiply-accumulate, restoring square
// root and restoring division with round half away from zero, all on one adder.
// ----------------------------------------------------------------------------
module sclp_engine import sclp_pkg::*; #(
	parameter int COORD_BITS = SCLP_COORD_BITS,
	localparam int AW = 4 * COORD_BITS + 4,
	localparam int QB = COORD_BITS + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  eng_cmd_t      cmd,
	input  logic [AW-1:0] opa,
	input  logic [AW-1:0] opb,
	output eng_sts_t      sts,
	output logic [AW-1:0] acc,
	output logic [2*COORD_BITS-1:0] root,
	output logic [QB:0]   quo
);

	localparam int CNTW = $clog2(QB + 2);
	localparam int ROOT_TOP = 4 * COORD_BITS - 2;
	localparam logic [AW-1:0] ROOT_BIT = {{(AW-1){1'b0}}, 1'b1} << ROOT_TOP;

	logic [AW-1:0] acc_q, a_q, b_q;
	logic [AW-1:0] lhs, rhs, sum;
	logic          sub, nonneg;
	eng_op_t       mode_q;
	div_ph_t       dph_q;
	logic          busy_q, done_q, neg_q, rnd_q, qneg_q;
	logic [CNTW-1:0] cnt_q;

	// the one shared adder / subtractor
	always_comb begin
		lhs = acc_q;
		rhs = a_q;
		sub = 1'b1;
		case (mode_q)
			EOP_MAC:  sub = neg_q;
			EOP_SQRT: rhs = a_q | b_q;
			EOP_DIV: begin
				case (dph_q)
					DPH_ABS: begin
						lhs = '0;
						rhs = acc_q;
					end
					DPH_RND: begin
						lhs = {acc_q[AW-2:0], 1'b0};
						rhs = opa;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		sum = lhs + (rhs ^ {AW{sub}}) + {{(AW-1){1'b0}}, sub};
		nonneg = !sum[AW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mode_q <= EOP_MAC;
			dph_q  <= DPH_ABS;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				mode_q <= cmd.op;
				dph_q  <= DPH_ABS;
			end else if (busy_q) begin
				case (mode_q)
					EOP_DIV: begin
						case (dph_q)
							DPH_ABS: begin
								dph_q <= DPH_STEP;
								cnt_q <= CNTW'(QB + 1);
							end
							DPH_STEP: begin
								cnt_q <= cnt_q - 1'b1;
								if (cnt_q == CNTW'(1))
									dph_q <= DPH_RND;
							end
							default: begin
								busy_q <= 1'b0;
								done_q <= 1'b1;
							end
						endcase
					end
					default: begin
						if (b_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= cmd.neg;
			case (cmd.op)
				EOP_MAC: begin
					if (cmd.clr)
						acc_q <= '0;
					a_q <= opa;
					b_q <= opb;
				end
				EOP_SQRT: begin
					a_q <= '0;
					b_q <= ROOT_BIT;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			case (mode_q)
				EOP_MAC: begin
					if (b_q != '0) begin
						if (b_q[0])
							acc_q <= sum;
						a_q <= a_q << 1;
						b_q <= b_q >> 1;
					end
				end
				EOP_SQRT: begin
					if (b_q != '0) begin
						if (nonneg) begin
							acc_q <= sum;
							a_q   <= (a_q >> 1) | b_q;
						end else begin
							a_q <= a_q >> 1;
						end
						b_q <= b_q >> 2;
					end
				end
				EOP_DIV: begin
					case (dph_q)
						DPH_ABS: begin
							qneg_q <= acc_q[AW-1];
							if (acc_q[AW-1])
								acc_q <= sum;
							a_q <= opa << QB;
							b_q <= '0;
						end
						DPH_STEP: begin
							if (nonneg)
								acc_q <= sum;
							b_q <= {b_q[AW-2:0], nonneg};
							a_q <= a_q >> 1;
						end
						default: rnd_q <= nonneg;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign sts  = '{done: done_q, rnd: rnd_q, qneg: qneg_q};
	assign acc  = acc_q;
	assign root = a_q[2*COORD_BITS-1:0];
	assign quo  = b_q[QB:0];

endmodule
`default_nettype wire

// File: tb/tb_segment_circle_lookahead_point_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_circle_lookahead_point_core
// Self-checking bench for the lookahead point core: directed corner requests,
// then mostly circle-crossing random segments under several idle patterns,
// each result checked against an in-bench exact integer predictor.
// ----------------------------------------------------------------------------
module tb_segment_circle_lookahead_point_core import sclp_pkg::*; ();

	localparam int CB = SCLP_COORD_BITS;
	localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
	localparam longint CMIN = -CMAX - 1;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic signed [CB-1:0] sx, sy, ex, ey, rx, ry;
		logic        [CB-2:0] rad;
	} seg_req_t;

	typedef struct {
		logic signed [CB-1:0] tx, ty;
		logic                 fr;
	} target_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CB-1:0] seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
	logic signed [CB-1:0] robot_x = '0, robot_y = '0;
	logic [CB-2:0] lookahead_radius = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CB-1:0] target_x, target_y;
	logic fresh;

	seg_req_t pending_reqs[$];
	target_t  expected_targets[$];
	longint   held_x = 0, held_y = 0;
	int       send_idle = 0, recv_stall = 0, hold_off = 0;
	int       errors = 0, n_results = 0, n_fresh = 0;

	segment_circle_lookahead_point_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
		.robot_x(robot_x), .robot_y(robot_y), .lookahead_radius(lookahead_radius),
		.out_valid(out_valid), .out_ready(out_ready),
		.target_x(target_x), .target_y(target_y), .fresh(fresh)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic wide_t isqrt(wide_t n);
		wide_t res, c;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (wide_t'(1) << b);
			if (c * c <= n) res = c;
		end
		return res;
	endfunction

	// round half away from zero, quotient clamped to 2^40
	function automatic longint round_div(wide_t n, wide_t d);
		wide_t a, q, rm;
		a = (n < 0) ? -n : n;
		q = a / d;
		rm = a % d;
		if (rm * 2 >= d) q = q + 1;
		if (q > (wide_t'(1) << 40)) q = wide_t'(1) << 40;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp_coord(longint v);
		return v > CMAX ? CMAX : (v < CMIN ? CMIN : v);
	endfunction

	function automatic target_t lookahead_target(seg_req_t r);
		longint sx, sy, ex, ey, rx, ry, dx, dy, mx, my, x1, x2, y1, y2, lx, hx, ly, hy;
		wide_t len2, dd, disc, q, t, u, e1, e2, rr;
		bit v1, v2;
		target_t res;
		sx = r.sx; sy = r.sy; ex = r.ex; ey = r.ey; rx = r.rx; ry = r.ry;
		rr = wide_t'(r.rad);
		dx = ex - sx; dy = ey - sy; mx = sx - rx; my = sy - ry;
		len2 = wide_t'(dx) * dx + wide_t'(dy) * dy;
		res.fr = 1'b0;
		if (len2 != 0) begin
			dd = wide_t'(mx) * dy - wide_t'(dx) * my;
			disc = rr * rr * len2 - dd * dd;
			if (disc >= 0) begin
				q = isqrt(disc);
				t = (dy < 0 ? -wide_t'(dx) : wide_t'(dx)) * q;
				u = (dy < 0 ? -wide_t'(dy) : wide_t'(dy)) * q;
				x1 = round_div(dd * dy + t, len2) + rx;
				x2 = round_div(dd * dy - t, len2) + rx;
				y1 = round_div(-dd * dx + u, len2) + ry;
				y2 = round_div(-dd * dx - u, len2) + ry;
				lx = sx < ex ? sx : ex; hx = sx < ex ? ex : sx;
				ly = sy < ey ? sy : ey; hy = sy < ey ? ey : sy;
				v1 = lx <= x1 && x1 <= hx && ly <= y1 && y1 <= hy;
				v2 = lx <= x2 && x2 <= hx && ly <= y2 && y2 <= hy;
				if (v1 && v2) begin
					e1 = wide_t'(x1 - ex) * (x1 - ex) + wide_t'(y1 - ey) * (y1 - ey);
					e2 = wide_t'(x2 - ex) * (x2 - ex) + wide_t'(y2 - ey) * (y2 - ey);
					// tie goes to the minus point
					if (e1 >= e2) v1 = 0;
				end
				if (v1 || v2) begin
					held_x = clamp_coord(v1 ? x1 : x2);
					held_y = clamp_coord(v1 ? y1 : y2);
					res.fr = 1'b1;
				end
			end
		end
		res.tx = held_x[CB-1:0];
		res.ty = held_y[CB-1:0];
		return res;
	endfunction

	// driver: predict on acceptance, then present the next queued request
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seg_req_t acc;
				acc.sx = seg_start_x; acc.sy = seg_start_y; acc.ex = seg_end_x;
				acc.ey = seg_end_y; acc.rx = robot_x; acc.ry = robot_y;
				acc.rad = lookahead_radius;
				expected_targets.push_back(lookahead_target(acc));
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
					seg_req_t nx;
					nx = pending_reqs.pop_front();
					seg_start_x <= nx.sx; seg_start_y <= nx.sy;
					seg_end_x <= nx.ex; seg_end_y <= nx.ey;
					robot_x <= nx.rx; robot_y <= nx.ry;
					lookahead_radius <= nx.rad;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				target_t ex;
				n_results++;
				if (fresh) n_fresh++;
				if (expected_targets.size() == 0) begin
					$display("%0t unexpected result x=%0d y=%0d fresh=%0b", $time,
						target_x, target_y, fresh);
					errors++;
				end else begin
					ex = expected_targets.pop_front();
					if (target_x !== ex.tx) begin
						$display("%0t target_x exp %0d got %0d", $time, ex.tx, target_x);
						errors++;
					end
					if (target_y !== ex.ty) begin
						$display("%0t target_y exp %0d got %0d", $time, ex.ty, target_y);
						errors++;
					end
					if (fresh !== ex.fr) begin
						$display("%0t fresh exp %0b got %0b", $time, ex.fr, fresh);
						errors++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	function automatic seg_req_t mk_req(longint sx, longint sy, longint ex, longint ey,
		longint rx, longint ry, longint rad);
		seg_req_t r;
		r.sx = CB'(sx); r.sy = CB'(sy); r.ex = CB'(ex); r.ey = CB'(ey);
		r.rx = CB'(rx); r.ry = CB'(ry); r.rad = (CB-1)'(rad);
		return r;
	endfunction

	function automatic seg_req_t rand_req();
		seg_req_t r;
		int kind, span;
		longint bx, by, px, py;
		real fx, fy, f;
		kind = int'($urandom_range(99));
		if (kind < 12) begin
			r.sx = CB'($urandom); r.sy = CB'($urandom);
			r.ex = CB'($urandom); r.ey = CB'($urandom);
			r.rx = CB'($urandom); r.ry = CB'($urandom); r.rad = (CB-1)'($urandom);
		end else begin
			span = ($urandom_range(9) == 0) ? 22 : int'($urandom_range(16, 4));
			bx = $signed($urandom) >>> 10; by = $signed($urandom) >>> 10;
			r.sx = CB'(bx + ($signed($urandom) >>> (32 - span)));
			r.sy = CB'(by + ($signed($urandom) >>> (32 - span)));
			r.ex = (kind < 18) ? r.sx : CB'(bx + ($signed($urandom) >>> (32 - span)));
			r.ey = (kind < 18) ? r.sy : CB'(by + ($signed($urandom) >>> (32 - span)));
			r.rx = CB'(bx + ($signed($urandom) >>> (32 - span + 1)));
			r.ry = CB'(by + ($signed($urandom) >>> (32 - span + 1)));
			// aim the circle at a point on or just past the segment
			f = $urandom_range(1200) / 1000.0;
			px = r.sx + longint'(f * (r.ex - r.sx));
			py = r.sy + longint'(f * (r.ey - r.sy));
			fx = px - r.rx; fy = py - r.ry;
			r.rad = (CB-1)'(longint'($sqrt(fx * fx + fy * fy)) +
				$signed($urandom_range(4)) - 2);
			if (kind < 24) r.rad = (CB-1)'($urandom_range(1 << (span - 2)));
		end
		return r;
	endfunction

	task automatic drain();
		while (pending_reqs.size() != 0 || in_valid || expected_targets.size() != 0)
			@(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	initial begin
		int n_sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// zero length, miss, tangent, corners of the coordinate range
		pending_reqs.push_back(mk_req(100, 100, 100, 100, 0, 0, 500));
		pending_reqs.push_back(mk_req(-1000, 0, 1000, 0, 0, 0, 300));
		pending_reqs.push_back(mk_req(-1000, 500, 1000, 500, 0, 0, 100));
		pending_reqs.push_back(mk_req(-1000, 500, 1000, 500, 0, 0, 500));
		pending_reqs.push_back(mk_req(0, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(mk_req(-100, -100, 100, 100, 0, 0, 0));
		pending_reqs.push_back(mk_req(CMIN, CMIN, CMAX, CMAX, 0, 0, CMAX));
		pending_reqs.push_back(mk_req(CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX));
		pending_reqs.push_back(mk_req(CMIN, 0, CMAX, 0, CMAX, CMIN, CMAX));
		pending_reqs.push_back(mk_req(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX));
		pending_reqs.push_back(mk_req(0, CMIN, 0, CMAX, 0, 0, 1000));
		pending_reqs.push_back(mk_req(CMIN, CMAX, CMAX, CMAX, 0, CMAX, 0));
		pending_reqs.push_back(mk_req(-5000, 3000, 7000, -2000, 100, -50, 2500));
		pending_reqs.push_back(mk_req(7000, -2000, -5000, 3000, 100, -50, 2500));
		pending_reqs.push_back(mk_req(0, -800, 0, 800, 0, 0, 400));
		pending_reqs.push_back(mk_req(-1, -1, 0, 0, CMAX, CMAX, CMAX));
		drain();
		n_sent = 16;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 38 : 73) : 0;
			recv_stall = (ph == 2) ? 73 : ((ph == 3) ? 38 : 0);
			for (int i = 0; i < 235; i++) pending_reqs.push_back(rand_req());
			if (ph == 0) hold_off = 3000;
			drain();
			n_sent += 235;
		end
		$display("covered %0d requests in four idle patterns, %0d results, %0d fresh",
			n_sent, n_results, n_fresh);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: files.f
sv/sclp_pkg.sv
sv/sclp_engine.sv
sv/segment_circle_lookahead_point_core.sv
tb/tb_segment_circle_lookahead_point_core.sv
